>>> hdl/sli_pkg.sv
// Shared types and codes for the sorted list insert block.
// Used by sli_cell and sorted_list_insert; no dependencies.
`timescale 1ns / 1ps

package sli_pkg;

  // Request function codes
  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_READOUT = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_ENTRY    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_READ = 1'b1
  } ctl_state_t;

  // Per-cycle operation applied to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned PositionWidth = 4;
  localparam int unsigned FillWidth     = 5;

  // Request beat
  typedef struct packed {
    func_t                   func;
    logic signed [ValueWidth-1:0] value;
  } req_t;

  // Result beat
  typedef struct packed {
    status_t                      status;
    logic signed [ValueWidth-1:0] entry_value;
    logic [PositionWidth-1:0]     position;
    logic [FillWidth-1:0]         fill_count;
    logic                         last;
  } rsp_t;

  // Broadcast control from the controller to all cells
  typedef struct packed {
    cell_op_t                     op;
    logic signed [ValueWidth-1:0] ins_value;
    logic signed [ValueWidth-1:0] head_value;
  } cell_ctrl_t;

endpackage

>>> hdl/sli_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the
// value being inserted and shifts or rotates with its neighbors. Uses sli_pkg.
`timescale 1ns / 1ps

module sli_cell
  import sli_pkg::*;
(
  input  logic                         clk,
  input  cell_ctrl_t                   ctrl,
  input  logic                         occupied,
  input  logic                         tail,
  input  logic                         left_le,
  input  logic signed [ValueWidth-1:0] left_value,
  input  logic signed [ValueWidth-1:0] right_value,
  output logic                         le,
  output logic signed [ValueWidth-1:0] value
);

  logic signed [ValueWidth-1:0] value_next;

  // Cell is occupied and its held value is less than or equal to the incoming one
  assign le = occupied && (value <= ctrl.ins_value);

  // Keep, take the new value, shift right on insert, or rotate left on readout
  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (le) begin
          value_next = value;
        end else if (left_le) begin
          value_next = ctrl.ins_value;
        end else begin
          value_next = left_value;
        end
      end
      CELL_ROTATE: begin
        value_next = tail ? ctrl.head_value : right_value;
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> hdl/sorted_list_insert.sv
// Top level of the sorted list insert block: controller, count and result
// register around a chain of sli_cell instances. Uses sli_pkg.
`timescale 1ns / 1ps

// Holds up to DEPTH signed 32-bit values in ascending order in a chain of
// cells; equal values keep arrival order. On an insert all cells compare
// with the new value at once and those above the slot shift up by one. An
// insert into a full store is dropped and reported as rejected. A readout
// of an empty store gives an empty beat; else the read state streams one
// held value per cycle unless stalled: the chain rotates toward cell zero,
// which feeds the result register, and after the last entry it is back in
// its original order. No new request is taken while a readout streams. The
// result register frees on the cycle its beat is taken, so back-to-back
// inserts run at one per cycle when the result side does not stall.

module sorted_list_insert
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ctl_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] rd_idx, rd_idx_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;

  cell_ctrl_t                   ctrl;
  logic [DEPTH-1:0]             cell_le;
  logic [DEPTH-1:0]             cell_occ;
  logic [DEPTH-1:0]             cell_tail;
  logic [DEPTH-1:0]             boundary;
  logic signed [ValueWidth-1:0] cell_value [DEPTH];
  logic [IW-1:0]                slot;

  logic out_free;
  logic accept;
  logic full;
  logic rd_last;

  assign out_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != CTL_IDLE) || !out_free;
  assign accept = req_valid && !req_stall;
  assign full = (count == CW'(DEPTH));
  assign rd_last = ((CW'(rd_idx) + CW'(1)) == count);

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         left_le;
    logic signed [ValueWidth-1:0] left_value;
    logic signed [ValueWidth-1:0] right_value;

    assign cell_occ[i]  = (count > CW'(i));
    assign cell_tail[i] = (count == CW'(i + 1));

    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_value = ctrl.ins_value;
    end else begin : g_body
      assign left_le    = cell_le[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    assign boundary[i] = left_le && !cell_le[i];

    sli_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cell_occ[i]),
      .tail        (cell_tail[i]),
      .left_le     (left_le),
      .left_value  (left_value),
      .right_value (right_value),
      .le          (cell_le[i]),
      .value       (cell_value[i])
    );
  end

  // Encode the insert slot from the one-hot boundary
  always_comb begin
    slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (boundary[i]) begin
        slot = slot | IW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE: begin
        if (accept && (req.func == FUNC_READOUT) && (count != '0)) begin
          state_next = CTL_READ;
        end
      end
      CTL_READ: begin
        if (out_free && rd_last) begin
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  // Cell control, count, readout index and result beat
  always_comb begin
    ctrl.op         = CELL_HOLD;
    ctrl.ins_value  = req.value;
    ctrl.head_value = cell_value[0];
    count_next      = count;
    rd_idx_next     = rd_idx;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    unique case (state)
      CTL_IDLE: begin
        rd_idx_next = '0;
        if (accept) begin
          rsp_valid_next = 1'b1;
          if (req.func == FUNC_INSERT) begin
            if (full) begin
              rsp_next = '{status: ST_REJECTED, entry_value: req.value,
                           position: '0, fill_count: FillWidth'(count),
                           last: 1'b1};
            end else begin
              ctrl.op    = CELL_INSERT;
              count_next = count + CW'(1);
              rsp_next   = '{status: ST_INSERTED, entry_value: req.value,
                             position: PositionWidth'(slot),
                             fill_count: FillWidth'(count + CW'(1)),
                             last: 1'b1};
            end
          end else if (count == '0) begin
            rsp_next = '{status: ST_EMPTY, entry_value: '0, position: '0,
                         fill_count: '0, last: 1'b1};
          end else begin
            rsp_valid_next = 1'b0;
          end
        end
      end
      CTL_READ: begin
        if (out_free) begin
          ctrl.op        = CELL_ROTATE;
          rsp_valid_next = 1'b1;
          rsp_next       = '{status: ST_ENTRY, entry_value: cell_value[0],
                             position: PositionWidth'(rd_idx),
                             fill_count: FillWidth'(count), last: rd_last};
          rd_idx_next    = rd_idx + IW'(1);
        end
      end
      default: begin
        ctrl.op = CELL_HOLD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_idx    <= rd_idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for sorted_list_insert: a directed table, then random
// beats checked against an in-bench sorted-list predictor. Depends on sli_pkg.
`timescale 1ns / 1ps

module tb_top
  import sli_pkg::*;
();

  localparam int unsigned LIST_DEPTH    = 16;
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned IDLE_PCT      = 8;
  localparam int unsigned SEND_CALM_LO  = 60;
  localparam int unsigned SEND_CALM_HI  = 120;
  localparam int unsigned TAKE_CALM_LO  = 300;
  localparam int unsigned TAKE_CALM_HI  = 600;
  localparam int unsigned HOLD_AT_BEAT  = 150;
  localparam int unsigned HOLD_CYCLES   = 100;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  // One row of the directed sequence; known rows carry their result inline
  typedef struct packed {
    func_t                func;
    logic signed [31:0]   value;
    logic                 known;
    rsp_t                 want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Predictor state: held values in ascending order and their count
  logic signed [31:0] held_vals [LIST_DEPTH];
  int unsigned        held_n;
  rsp_t               step_rsp [$];
  rsp_t               pending_rsp [$];
  int unsigned        err_count = 0;
  int unsigned        beats_taken = 0;
  int unsigned        quiet_cycles = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{FUNC_READOUT, 32'sd0,        1'b1, '{ST_EMPTY, 32'sd0, 4'd0, 5'd0, 1'b1}},
    '{FUNC_INSERT,  VAL_MAX,       1'b1, '{ST_INSERTED, VAL_MAX, 4'd0, 5'd1, 1'b1}},
    '{FUNC_INSERT,  VAL_MIN,       1'b1, '{ST_INSERTED, VAL_MIN, 4'd0, 5'd2, 1'b1}},
    '{FUNC_INSERT,  32'sd0,        1'b1, '{ST_INSERTED, 32'sd0, 4'd1, 5'd3, 1'b1}},
    '{FUNC_INSERT,  32'sd0,        1'b1, '{ST_INSERTED, 32'sd0, 4'd2, 5'd4, 1'b1}},
    '{FUNC_INSERT,  -32'sd1,       1'b0, '0},
    '{FUNC_INSERT,  VAL_MAX,       1'b0, '0},
    '{FUNC_READOUT, 32'sh1234_5678, 1'b0, '0},
    '{FUNC_INSERT,  VAL_MIN,       1'b0, '0},
    '{FUNC_INSERT,  32'sh5555_5555, 1'b0, '0},
    '{FUNC_INSERT,  32'shAAAA_AAAA, 1'b0, '0},
    '{FUNC_INSERT,  32'sd1,        1'b0, '0},
    '{FUNC_INSERT,  -32'sd2,       1'b0, '0},
    '{FUNC_INSERT,  32'sd12345,    1'b0, '0},
    '{FUNC_INSERT,  32'sh7FFF_FFFE, 1'b0, '0},
    '{FUNC_INSERT,  32'sh8000_0001, 1'b0, '0},
    '{FUNC_READOUT, 32'shFFFF_FFFF, 1'b0, '0},
    '{FUNC_INSERT,  32'sh0F0F_0F0F, 1'b0, '0},
    '{FUNC_INSERT,  32'shF0F0_F0F0, 1'b0, '0},
    '{FUNC_INSERT,  32'sd42,       1'b1, '{ST_REJECTED, 32'sd42, 4'd0, 5'd16, 1'b1}},
    '{FUNC_INSERT,  VAL_MIN,       1'b1, '{ST_REJECTED, VAL_MIN, 4'd0, 5'd16, 1'b1}},
    '{FUNC_READOUT, 32'sd0,        1'b0, '0}
  };

  sorted_list_insert #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work out the result beats one request causes and advance the held list
  function automatic void sort_list_step(input req_t beat);
    int slot;
    logic signed [31:0] v;
    step_rsp.delete();
    v = $signed(beat.value);
    if (beat.func == FUNC_INSERT) begin
      if (held_n >= LIST_DEPTH) begin
        step_rsp.push_back('{ST_REJECTED, v, 4'd0, 5'(held_n), 1'b1});
      end else begin
        slot = 0;
        while (slot < int'(held_n) && held_vals[slot] <= v) slot++;
        for (int i = int'(held_n); i > slot; i--) held_vals[i] = held_vals[i-1];
        held_vals[slot] = v;
        held_n++;
        step_rsp.push_back('{ST_INSERTED, v, 4'(slot), 5'(held_n), 1'b1});
      end
    end else if (held_n == 0) begin
      step_rsp.push_back('{ST_EMPTY, 32'sd0, 4'd0, 5'd0, 1'b1});
    end else begin
      for (int i = 0; i < int'(held_n); i++)
        step_rsp.push_back('{ST_ENTRY, held_vals[i], 4'(i), 5'(held_n),
                             (i == int'(held_n) - 1)});
    end
  endfunction

  // Compare one taken result beat against the oldest pending one
  task automatic check_beat(input rsp_t got);
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("unexpected result beat: status %0d value %0d", got.status,
             got.entry_value);
      err_count++;
    end else begin
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        err_count++;
      end
      if (got.entry_value !== want.entry_value) begin
        $error("entry_value: expected %0d, got %0d", want.entry_value,
               got.entry_value);
        err_count++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        err_count++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count,
               got.fill_count);
        err_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        err_count++;
      end
    end
  endtask

  // Offer one request beat, idling first at random, and wait until taken
  task automatic send_beat(input req_t beat, input bit calm);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Result side: check taken beats, stall at random, hold off once for long
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        check_beat(rsp);
        beats_taken++;
        if (beats_taken == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (beats_taken >= TAKE_CALM_LO && beats_taken < TAKE_CALM_HI) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Request side: reset, directed table, random beats, then drain and report
  initial begin
    req_t beat;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    held_n    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[k]) begin
      beat.func  = dir_table[k].func;
      beat.value = dir_table[k].value;
      send_beat(beat, 1'b0);
      sort_list_step(beat);
      if (dir_table[k].known) pending_rsp.push_back(dir_table[k].want);
      else foreach (step_rsp[j]) pending_rsp.push_back(step_rsp[j]);
    end

    // Store is full from here on: readouts stream all sixteen entries and
    // inserts come back rejected with their value
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      beat.func = ($urandom_range(3) == 0) ? FUNC_READOUT : FUNC_INSERT;
      case ($urandom_range(7))
        0:       beat.value = VAL_MIN;
        1:       beat.value = VAL_MAX;
        2:       beat.value = -32'sd1;
        3:       beat.value = 32'sd0;
        default: beat.value = $urandom;
      endcase
      send_beat(beat, n >= SEND_CALM_LO && n < SEND_CALM_HI);
      sort_list_step(beat);
      foreach (step_rsp[j]) pending_rsp.push_back(step_rsp[j]);
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/sli_pkg.sv
hdl/sli_cell.sv
hdl/sorted_list_insert.sv
bench/tb_top.sv
